FILE: hw/rtl/ipid_pkg.sv
// ipid_pkg: types and constants shared by the incremental pid controller
// request and result structs, configuration and history structs, register map
// no dependencies
`default_nettype none

package ipid_pkg;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    typedef enum logic [2:0] {
        REG_KP_GAIN     = 3'd0,
        REG_KI_GAIN     = 3'd1,
        REG_KD_GAIN     = 3'd2,
        REG_OUT_MIN     = 3'd3,
        REG_OUT_MAX     = 3'd4,
        REG_ERROR_LIMIT = 3'd5
    } reg_index_t;

    localparam logic [1:0] LIM_NONE = 2'd0;
    localparam logic [1:0] LIM_MAX  = 2'd1;
    localparam logic [1:0] LIM_MIN  = 2'd2;

    localparam logic signed [31:0] OUT_MIN_RESET     = 32'sh8000_0000;
    localparam logic signed [31:0] OUT_MAX_RESET     = 32'sh7fff_ffff;
    localparam logic [15:0]        ERROR_LIMIT_RESET = 16'd500;

    typedef struct packed {
        logic signed [15:0] setpoint;
        logic signed [15:0] measurement;
    } sample_t;

    typedef struct packed {
        logic signed [31:0] drive;
        logic [1:0]         limit_state;
        logic               error_reset;
    } result_t;

    typedef struct packed {
        logic signed [23:0] kp_gain;
        logic signed [23:0] ki_gain;
        logic signed [23:0] kd_gain;
        logic signed [31:0] out_min;
        logic signed [31:0] out_max;
        logic [15:0]        error_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [16:0] prev_error;
        logic signed [16:0] prev_prev_error;
        logic signed [31:0] prev_output;
    } hist_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ipid_cfg.sv
// ipid_cfg: apb register file holding gains, clamp bounds and error limit
// depends on ipid_pkg
`default_nettype none

module ipid_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ipid_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [ipid_pkg::DATA_W-1:0]  pwdata,
    output logic      [ipid_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    output ipid_pkg::cfg_t                    cfg
);
    import ipid_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    reg_index_t wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = reg_index_t'(paddr[ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_gain     <= '0;
            cfg_reg.ki_gain     <= '0;
            cfg_reg.kd_gain     <= '0;
            cfg_reg.out_min     <= OUT_MIN_RESET;
            cfg_reg.out_max     <= OUT_MAX_RESET;
            cfg_reg.error_limit <= ERROR_LIMIT_RESET;
        end
        else if (wr_en)
        begin
            case (wr_idx)
                REG_KP_GAIN:     cfg_reg.kp_gain     <= pwdata[23:0];
                REG_KI_GAIN:     cfg_reg.ki_gain     <= pwdata[23:0];
                REG_KD_GAIN:     cfg_reg.kd_gain     <= pwdata[23:0];
                REG_OUT_MIN:     cfg_reg.out_min     <= pwdata;
                REG_OUT_MAX:     cfg_reg.out_max     <= pwdata;
                REG_ERROR_LIMIT: cfg_reg.error_limit <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (wr_idx)
            REG_KP_GAIN:     prdata = {8'h00, cfg_reg.kp_gain};
            REG_KI_GAIN:     prdata = {8'h00, cfg_reg.ki_gain};
            REG_KD_GAIN:     prdata = {8'h00, cfg_reg.kd_gain};
            REG_OUT_MIN:     prdata = cfg_reg.out_min;
            REG_OUT_MAX:     prdata = cfg_reg.out_max;
            REG_ERROR_LIMIT: prdata = {16'h0000, cfg_reg.error_limit};
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ipid_core.sv
// ipid_core: combinational velocity-form pid update with error guard and clamp
// depends on ipid_pkg
`default_nettype none

module ipid_core (
    input  wire ipid_pkg::cfg_t    cfg,
    input  wire ipid_pkg::sample_t sample,
    input  wire ipid_pkg::hist_t   hist,
    output ipid_pkg::result_t      result,
    output ipid_pkg::hist_t        hist_next
);
    import ipid_pkg::*;

    logic signed [16:0] err_raw;
    logic signed [17:0] err_wide;
    logic signed [17:0] lim_s;
    logic               over;
    logic signed [16:0] e0;
    logic signed [16:0] e1;
    logic signed [16:0] e2;
    logic signed [31:0] last;
    logic signed [17:0] d_p;
    logic signed [19:0] d_d;
    logic signed [17:0] d_i;
    logic signed [41:0] prod_p;
    logic signed [43:0] prod_d;
    logic signed [41:0] prod_i;
    logic signed [45:0] acc;
    logic signed [45:0] acc_rnd;
    logic signed [37:0] step;
    logic signed [38:0] sum;

    always_comb
    begin
        err_raw  = 17'(sample.setpoint) - 17'(sample.measurement);
        err_wide = 18'(err_raw);
        lim_s    = $signed({2'b00, cfg.error_limit});
        over     = (err_wide > lim_s) || (err_wide < -lim_s);

        // history cleared on an out-of-range error
        e0   = over ? '0 : err_raw;
        e1   = over ? '0 : hist.prev_error;
        e2   = over ? '0 : hist.prev_prev_error;
        last = over ? '0 : hist.prev_output;

        d_p = 18'(e0) - 18'(e1);
        d_d = 20'(e0) - 20'(e1) - 20'(e1) + 20'(e2);
        d_i = 18'(e0) + 18'(e1);

        prod_p = 42'(cfg.kp_gain) * 42'(d_p);
        prod_d = 44'(cfg.kd_gain) * 44'(d_d);
        prod_i = 42'(cfg.ki_gain) * 42'(d_i);

        acc     = 46'(prod_p) + 46'(prod_d) + 46'(prod_i);
        // q.16 to q.8, round half up
        acc_rnd = acc + 46'sd128;
        step    = $signed(acc_rnd[45:8]);
        sum     = 39'(last) + 39'(step);

        result.error_reset = over;
        if (sum > 39'(cfg.out_max))
        begin
            result.drive       = cfg.out_max;
            result.limit_state = LIM_MAX;
        end
        else if (sum < 39'(cfg.out_min))
        begin
            result.drive       = cfg.out_min;
            result.limit_state = LIM_MIN;
        end
        else
        begin
            result.drive       = sum[31:0];
            result.limit_state = LIM_NONE;
        end

        hist_next.prev_error      = e0;
        hist_next.prev_prev_error = e1;
        hist_next.prev_output     = result.drive;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/incremental_pid_with_clamp.sv
// incremental_pid_with_clamp: top level of the velocity-form pid controller
// depends on ipid_pkg, ipid_cfg, ipid_core
//
//   channel   direction  handshake                   payload
//   sample    in         sample_valid/sample_ready   ipid_pkg::sample_t
//   result    out        result_valid/result_ready   ipid_pkg::result_t
//   apb       in/out     psel/penable/pready         paddr, pwdata, prdata
//
// one request per cycle sustained while results are taken; a result passes from
// the input register through the combinational update into the result register
// the history loop (last output, last two errors) closes via the history register
// reset clears the history to zero and loads the register reset values
// a stalled result holds both stages; a new request is still taken while
// the input register is empty
`default_nettype none

module incremental_pid_with_clamp (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         sample_valid,
    output logic                              sample_ready,
    input  wire ipid_pkg::sample_t            sample,
    output logic                              result_valid,
    input  wire logic                         result_ready,
    output ipid_pkg::result_t                 result,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ipid_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [ipid_pkg::DATA_W-1:0]  pwdata,
    output logic      [ipid_pkg::DATA_W-1:0]  prdata,
    output logic                              pready
);
    import ipid_pkg::*;

    cfg_t    cfg;
    sample_t in_reg;
    logic    in_valid_reg;
    result_t out_reg;
    logic    out_valid_reg;
    hist_t   hist_reg;
    hist_t   hist_next;
    result_t res_next;
    logic    advance;

    ipid_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ipid_core u_core (
        .cfg       (cfg),
        .sample    (in_reg),
        .hist      (hist_reg),
        .result    (res_next),
        .hist_next (hist_next)
    );

    assign advance      = in_valid_reg && (!out_valid_reg || result_ready);
    assign sample_ready = !in_valid_reg || advance;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hist_reg      <= '0;
        end
        else
        begin
            if (sample_ready)
            begin
                in_valid_reg <= sample_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                hist_reg      <= hist_next;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            in_reg <= sample;
        end
        if (advance)
        begin
            out_reg <= res_next;
        end
    end

endmodule

`default_nettype wire
